### hw/rtl/ecqm_pkg.sv
// Shared constants, widths, status codes and helpers for the M/M/c queue metrics block.
// No dependencies; imported by every module of the block.
package ecqm_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int WORK_FRAC       = 28;
    localparam int WORK_SHIFT      = WORK_FRAC - FRAC_BITS;
    localparam int DEF_MAX_SERVERS = 16;

    localparam int RATE_W  = 32;
    localparam int OUT_W   = 32;
    localparam int IDLE_W  = FRAC_BITS + 1;
    localparam int CNT_W   = 5;
    localparam int PROB_W  = WORK_FRAC + 1;
    localparam int DEN_W   = PROB_W + 1;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 40;
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = 64;
    localparam int DIGIT_W   = 8;

    localparam logic [PROB_W-1:0] WORK_ONE = PROB_W'(1) << WORK_FRAC;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_UNSTABLE = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;

    function automatic logic [OUT_W-1:0] sat32(input logic [63:0] v);
        logic [OUT_W-1:0] res;
        if (v[63:OUT_W] != '0) begin
            res = '1;
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/ecqm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by the whole sequence.
// Depends on ecqm_pkg for operand widths.
module ecqm_div
    import ecqm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);
    localparam int IT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [IT_W-1:0]      r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
                r_num <= {r_num[DIV_NUM_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

### hw/rtl/ecqm_mul.sv
// Digit-serial multiplier: one 8-bit digit of the second operand per cycle.
// Depends on ecqm_pkg for operand widths.
module ecqm_mul
    import ecqm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [PROB_W-1:0]  i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);
    localparam int STEPS = MUL_B_W / DIGIT_W;
    localparam int ST_W  = $clog2(STEPS);

    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [ST_W-1:0]    r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [MUL_A_W+DIGIT_W-1:0] part;

    assign part = r_a * r_b[MUL_B_W-1 -: DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= MUL_B_W'(i_b);
            end else if (r_busy) begin
                r_acc <= (r_acc << DIGIT_W) + MUL_P_W'(part);
                r_b   <= r_b << DIGIT_W;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ST_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hw/rtl/erlang_c_queue_metrics.sv
// Top level of the M/M/c (Erlang C) queue metrics block: sequencer and working registers.
// Depends on ecqm_pkg, ecqm_div and ecqm_mul.
//
// Usage: a request on the input channel (i_valid / o_ready) carries an arrival rate and a
// per-server service rate in unsigned Q16.16 and a server count. One result per request
// leaves on the output channel (o_valid / i_ready): P0, L, W, Lq, Wq, utilization and status.
// The block works on one request at a time; o_ready is high only while the sequencer idles.
// The work runs on one shared 64-step restoring divider and one shared digit-serial
// multiplier. The Erlang B recursion takes one product, one quotient and one product per
// server, so a stable request takes 8 + c quotients and 2c + 3 products from acceptance to
// result. A request with a zero rate skips the arithmetic and goes straight to the final
// load, an unstable one finishes after the utilization quotient. Server counts above
// MAX_SERVERS are clamped. Latency is dominated by the divider.
// The result sits in an output register: a stalled receiver does not stop the next request
// from being taken and computed; only the final load waits for the register to drain.
// Reset is synchronous and active low; it returns the sequencer to idle and drops o_valid.
module erlang_c_queue_metrics
    import ecqm_pkg::*;
#(
    parameter int MAX_SERVERS = DEF_MAX_SERVERS
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RATE_W-1:0] i_arrival_rate,
    input  logic [RATE_W-1:0] i_service_rate,
    input  logic [CNT_W-1:0]  i_server_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IDLE_W-1:0] o_idle_prob,
    output logic [OUT_W-1:0]  o_mean_in_system,
    output logic [OUT_W-1:0]  o_mean_time_in_system,
    output logic [OUT_W-1:0]  o_mean_in_queue,
    output logic [OUT_W-1:0]  o_mean_queue_wait,
    output logic [OUT_W-1:0]  o_utilization,
    output logic [1:0]        o_status
);
    // Width of the clamped server count and of c*mu.
    localparam int CW    = $clog2(MAX_SERVERS + 1);
    localparam int IW    = (CW > CNT_W) ? CW : CNT_W;
    localparam int CMU_W = RATE_W + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_UTIL, S_RATIO, S_RHO, S_LX, S_LB, S_LP, S_DEN,
        S_ERL, S_P0M, S_P0D, S_LQM, S_LQD, S_W, S_WQ, S_FIN
    } t_state;

    t_state r_state;
    logic   r_wait;

    // Working registers of one request.
    logic [RATE_W-1:0]  r_lambda;
    logic [RATE_W-1:0]  r_mu;
    logic [CW-1:0]      r_c;
    logic [CW-1:0]      r_n;
    logic [CMU_W-1:0]   r_cmu;
    logic [MUL_A_W-1:0] r_ratio;
    logic [MUL_A_W-1:0] r_x;
    logic [PROB_W-1:0]  r_rho;
    logic [PROB_W-1:0]  r_omr;
    logic [PROB_W-1:0]  r_b;
    logic [PROB_W-1:0]  r_pi;
    logic [PROB_W-1:0]  r_erl;
    logic [PROB_W-1:0]  r_p0;
    logic [DEN_W-1:0]   r_den;
    logic [63:0]        r_tmp;
    logic [63:0]        r_lq;
    logic [63:0]        r_l;
    logic [OUT_W-1:0]   r_util;
    logic [OUT_W-1:0]   r_w;
    logic [OUT_W-1:0]   r_wq;
    logic [1:0]         r_stat;
    logic               r_out_valid;

    logic [CW-1:0]        c_clamp;
    logic [CMU_W-1:0]     cmu_in;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] quot;
    logic                 mul_start;
    logic                 mul_done;
    logic [MUL_A_W-1:0]   mul_a;
    logic [PROB_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]   prod;

    // Counts above MAX_SERVERS fall back to MAX_SERVERS.
    assign c_clamp = (IW'(i_server_count) > IW'(MAX_SERVERS)) ? CW'(MAX_SERVERS)
                                                             : CW'(i_server_count);
    assign cmu_in  = CMU_W'(i_service_rate) * CMU_W'(c_clamp);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // Each arithmetic state launches its unit once, then waits for the done pulse.
    assign div_start = !r_wait && (r_state inside {S_UTIL, S_RATIO, S_RHO, S_LB, S_ERL,
                                                   S_P0D, S_LQD, S_W, S_WQ});
    assign mul_start = !r_wait && (r_state inside {S_LX, S_LP, S_DEN, S_P0M, S_LQM});

    always_comb begin
        div_num = '0;
        div_den = '0;
        case (r_state)
            S_UTIL: begin
                div_num = DIV_NUM_W'(r_lambda) << FRAC_BITS;
                div_den = DIV_DEN_W'(r_cmu);
            end
            S_RATIO: begin
                div_num = DIV_NUM_W'(r_lambda) << WORK_FRAC;
                div_den = DIV_DEN_W'(r_mu);
            end
            S_RHO: begin
                div_num = DIV_NUM_W'(r_lambda) << WORK_FRAC;
                div_den = DIV_DEN_W'(r_cmu);
            end
            S_LB: begin
                div_num = DIV_NUM_W'(r_x) << WORK_FRAC;
                div_den = (DIV_DEN_W'(r_n) << WORK_FRAC) + DIV_DEN_W'(r_x);
            end
            S_ERL: begin
                div_num = DIV_NUM_W'(r_b) << WORK_FRAC;
                div_den = DIV_DEN_W'(r_den);
            end
            S_P0D: begin
                div_num = r_tmp;
                div_den = DIV_DEN_W'(r_den);
            end
            S_LQD: begin
                div_num = r_tmp;
                div_den = DIV_DEN_W'(r_omr);
            end
            S_W: begin
                div_num = (r_l >> WORK_SHIFT) << FRAC_BITS;
                div_den = DIV_DEN_W'(r_lambda);
            end
            S_WQ: begin
                div_num = (r_lq >> WORK_SHIFT) << FRAC_BITS;
                div_den = DIV_DEN_W'(r_lambda);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_LX: begin
                mul_a = r_ratio;
                mul_b = r_b;
            end
            S_LP: begin
                mul_a = MUL_A_W'(r_pi);
                mul_b = r_b;
            end
            S_DEN: begin
                mul_a = MUL_A_W'(r_rho);
                mul_b = r_b;
            end
            S_P0M: begin
                mul_a = MUL_A_W'(r_pi);
                mul_b = r_omr;
            end
            S_LQM: begin
                mul_a = MUL_A_W'(r_erl);
                mul_b = r_rho;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ecqm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    ecqm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (div_start || mul_start) begin
                r_wait <= 1'b1;
            end
            if (div_done || mul_done) begin
                r_wait <= 1'b0;
            end
            // In S_FIN the load below decides the output valid on its own.
            if (r_out_valid && i_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_lambda <= i_arrival_rate;
                        r_mu     <= i_service_rate;
                        r_c      <= c_clamp;
                        r_cmu    <= cmu_in;
                        r_util   <= '0;
                        r_p0     <= '0;
                        r_l      <= '0;
                        r_lq     <= '0;
                        r_w      <= '0;
                        r_wq     <= '0;
                        // A zero rate yields all-zero figures and skips the math.
                        if (i_arrival_rate == '0 || i_service_rate == '0) begin
                            r_stat  <= ST_ZERO;
                            r_state <= S_FIN;
                        end else begin
                            r_stat  <= ST_VALID;
                            r_state <= S_UTIL;
                        end
                    end
                end
                S_UTIL: begin
                    if (div_done) begin
                        r_util <= sat32(quot);
                        // Unstable when the total service capacity does not exceed demand.
                        if (r_cmu <= CMU_W'(r_lambda)) begin
                            r_stat  <= ST_UNSTABLE;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RATIO;
                        end
                    end
                end
                S_RATIO: begin
                    if (div_done) begin
                        r_ratio <= quot[MUL_A_W-1:0];
                        r_state <= S_RHO;
                    end
                end
                S_RHO: begin
                    if (div_done) begin
                        r_rho   <= quot[PROB_W-1:0];
                        r_omr   <= WORK_ONE - quot[PROB_W-1:0];
                        r_b     <= WORK_ONE;
                        r_pi    <= WORK_ONE;
                        r_n     <= CW'(1);
                        r_state <= S_LX;
                    end
                end
                S_LX: begin
                    if (mul_done) begin
                        r_x     <= prod[WORK_FRAC +: MUL_A_W];
                        r_state <= S_LB;
                    end
                end
                S_LB: begin
                    if (div_done) begin
                        r_b     <= quot[PROB_W-1:0];
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    if (mul_done) begin
                        r_pi <= r_pi - prod[WORK_FRAC +: PROB_W];
                        if (r_n == r_c) begin
                            r_state <= S_DEN;
                        end else begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_LX;
                        end
                    end
                end
                S_DEN: begin
                    if (mul_done) begin
                        r_den   <= DEN_W'(r_omr) + prod[WORK_FRAC +: DEN_W];
                        r_state <= S_ERL;
                    end
                end
                S_ERL: begin
                    if (div_done) begin
                        // Truncation can leave C a hair above one; limit it.
                        r_erl   <= (quot > DIV_NUM_W'(WORK_ONE)) ? WORK_ONE
                                                                 : quot[PROB_W-1:0];
                        r_state <= S_P0M;
                    end
                end
                S_P0M: begin
                    if (mul_done) begin
                        r_tmp   <= prod;
                        r_state <= S_P0D;
                    end
                end
                S_P0D: begin
                    if (div_done) begin
                        r_p0    <= quot[PROB_W-1:0];
                        r_state <= S_LQM;
                    end
                end
                S_LQM: begin
                    if (mul_done) begin
                        r_tmp   <= prod;
                        r_state <= S_LQD;
                    end
                end
                S_LQD: begin
                    if (div_done) begin
                        r_lq    <= quot;
                        r_l     <= quot + 64'(r_ratio);
                        r_state <= S_W;
                    end
                end
                S_W: begin
                    if (div_done) begin
                        r_w     <= sat32(quot);
                        r_state <= S_WQ;
                    end
                end
                S_WQ: begin
                    if (div_done) begin
                        r_wq    <= sat32(quot);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Load the output register once the previous result has left.
                    if (!r_out_valid || i_ready) begin
                        o_idle_prob           <= r_p0[WORK_SHIFT +: IDLE_W];
                        o_mean_in_system      <= sat32(r_l >> WORK_SHIFT);
                        o_mean_time_in_system <= r_w;
                        o_mean_in_queue       <= sat32(r_lq >> WORK_SHIFT);
                        o_mean_queue_wait     <= r_wq;
                        o_utilization         <= r_util;
                        o_status              <= r_stat;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/ecqm_chk.sv
// Port-level checker for erlang_c_queue_metrics, attached by the bind at the end of this file.
// Depends on ecqm_pkg for the status codes and widths.
module ecqm_chk
    import ecqm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [RATE_W-1:0] i_arrival_rate,
    input logic [RATE_W-1:0] i_service_rate,
    input logic [CNT_W-1:0]  i_server_count,
    input logic              o_valid,
    input logic              i_ready,
    input logic [IDLE_W-1:0] o_idle_prob,
    input logic [OUT_W-1:0]  o_mean_in_system,
    input logic [OUT_W-1:0]  o_mean_time_in_system,
    input logic [OUT_W-1:0]  o_mean_in_queue,
    input logic [OUT_W-1:0]  o_mean_queue_wait,
    input logic [OUT_W-1:0]  o_utilization,
    input logic [1:0]        o_status
);

    // No result is presented right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A result held by the receiver keeps its status.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_mean_in_system))
        else $error("stalled result changed");

    // The block computes one request at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

    // A zero-rate result carries no figures.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |-> o_idle_prob == '0 && o_utilization == '0 &&
            o_mean_in_system == '0 && o_mean_queue_wait == '0)
        else $error("zero-rate result has nonzero figures");

    // Idle probability never exceeds one, and an unstable result has none.
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_idle_prob <= (IDLE_W'(1) << FRAC_BITS) &&
            (o_status != ST_UNSTABLE || o_idle_prob == '0))
        else $error("idle probability out of range");

endmodule

bind erlang_c_queue_metrics ecqm_chk u_ecqm_chk (.*);
